// ----- rtl/kpi_pkg.sv -----
// Shared types and constants for the k-mer position index.
package kpi_pkg;

    // Default build parameters
    localparam int MAX_K_DEF    = 8;
    localparam int SLOTS_DEF    = 64;
    localparam int POS_BITS_DEF = 20;

    // Field widths
    localparam int OP_W       = 2;
    localparam int BASE_W     = 2;
    localparam int REF_W      = 32;
    localparam int TPOS_W     = 20;
    localparam int KLEN_W     = 4;
    localparam int CAP_W      = 7;
    localparam int HL_W       = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_TARGET = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KMER_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_CAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_LIMIT = 2'd2;

    // Register reset values
    localparam logic [KLEN_W-1:0] KMER_LEN_RST  = 4'd8;
    localparam logic [CAP_W-1:0]  BUCKET_CAP_RST = 7'd50;
    localparam logic [HL_W-1:0]   HIT_LIMIT_RST = 14'd10000;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_COUNT,
        ST_SLOT_RD,
        ST_SLOT_OUT
    } t_kpi_state;

    // Strobes from the sequencer to the table store
    typedef struct packed {
        logic clear_start;
        logic cnt_rd;
        logic cnt_wr;
        logic slot_rd;
        logic slot_wr;
    } t_kpi_store_cmd;

endpackage

// ----- rtl/kpi_store.sv -----
// Bucket count memory with clear sweep, and the position slot memory.
module kpi_store #(
    parameter int MAX_K    = kpi_pkg::MAX_K_DEF,
    parameter int SLOTS    = kpi_pkg::SLOTS_DEF,
    parameter int POS_BITS = kpi_pkg::POS_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kpi_pkg::t_kpi_store_cmd     i_cmd,
    input  logic [2*MAX_K-1:0]          i_key,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_slot_idx,
    input  logic [$clog2(SLOTS+1)-1:0]  i_cnt_wdata,
    input  logic [POS_BITS-1:0]         i_slot_wdata,
    output logic [$clog2(SLOTS+1)-1:0]  o_cnt_q,
    output logic [POS_BITS-1:0]         o_slot_q,
    output logic                        o_busy
);

    localparam int KEY_W       = 2 * MAX_K;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NUM_BUCKETS = 1 << KEY_W;
    localparam int NUM_SLOTS   = 1 << (KEY_W + IDX_W);

    logic [CNT_W-1:0]    r_cnt_mem [NUM_BUCKETS];
    logic [POS_BITS-1:0] r_slot_mem [NUM_SLOTS];
    logic [CNT_W-1:0]    r_cnt_q;
    logic [POS_BITS-1:0] r_slot_q;
    logic                r_clr_busy;
    logic [KEY_W-1:0]    r_clr_addr;

    // One bucket per cycle while sweeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (i_cmd.clear_start) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + KEY_W'(1);
            if (r_clr_addr == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_cnt_mem[r_clr_addr] <= '0;
        end else if (i_cmd.cnt_wr) begin
            r_cnt_mem[i_key] <= i_cnt_wdata;
        end
        if (i_cmd.cnt_rd) begin
            r_cnt_q <= r_cnt_mem[i_key];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.slot_wr) begin
            r_slot_mem[{i_key, i_slot_idx}] <= i_slot_wdata;
        end
        if (i_cmd.slot_rd) begin
            r_slot_q <= r_slot_mem[{i_key, i_slot_idx}];
        end
    end

    assign o_cnt_q  = r_cnt_q;
    assign o_slot_q = r_slot_q;
    assign o_busy   = r_clr_busy;

endmodule

// ----- rtl/kmer_position_index_core.sv -----
// Top level: k-mer position index sequencer, config registers and result register.
// Target base: accepted in idle; when a k-mer completes, a count read and a table update follow.
// Query base: accepted in idle; with a lookup, a count read follows, then a slot read and
//   a result load per hit, held while the result register is stalled; one item is in flight at a time.
// Clear: all 2^(2*MAX_K) bucket counts are zeroed, one bucket count per cycle.
// Reset (synchronous, active low) runs the same count sweep before the first item is taken.
module kmer_position_index_core #(
    parameter int MAX_K    = kpi_pkg::MAX_K_DEF,
    parameter int SLOTS    = kpi_pkg::SLOTS_DEF,
    parameter int POS_BITS = kpi_pkg::POS_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [kpi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kpi_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input words
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [kpi_pkg::OP_W-1:0]        i_operation,
    input  logic [kpi_pkg::BASE_W-1:0]      i_base,
    input  logic                            i_first_of_query,
    input  logic [kpi_pkg::REF_W-1:0]       i_query_start,
    // result words
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [kpi_pkg::TPOS_W-1:0]      o_target_pos,
    output logic [kpi_pkg::REF_W-1:0]       o_ref_start,
    output logic                            o_last
);

    localparam int KEY_W  = 2 * MAX_K;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KLEN_W = kpi_pkg::KLEN_W;
    localparam int HL_W   = kpi_pkg::HL_W;
    localparam int REF_W  = kpi_pkg::REF_W;
    localparam logic [KLEN_W-1:0]          MAX_K_L = KLEN_W'(MAX_K);
    localparam logic [kpi_pkg::CAP_W-1:0]  SLOTS_C = kpi_pkg::CAP_W'(SLOTS);

    kpi_pkg::t_kpi_state r_state, n_state;

    logic [KLEN_W-1:0]          r_kmer_len;
    logic [kpi_pkg::CAP_W-1:0]  r_bucket_cap;
    logic [HL_W-1:0]            r_hit_limit;

    logic [KEY_W-1:0]    r_tkey, n_tkey;
    logic [POS_BITS-1:0] r_tcount, n_tcount;
    logic [KEY_W-1:0]    r_qkey, n_qkey;
    logic [REF_W-1:0]    r_qoffset, n_qoffset;
    logic [REF_W-1:0]    r_qorigin, n_qorigin;
    logic [HL_W-1:0]     r_hits, n_hits;
    logic                r_qstopped, n_qstopped;
    logic                r_is_query, n_is_query;
    logic [REF_W-1:0]    r_ref_start, n_ref_start;
    logic [CNT_W-1:0]    r_n, n_n;
    logic [CNT_W-1:0]    r_idx, n_idx;

    logic                      r_out_valid, n_out_valid;
    logic [kpi_pkg::TPOS_W-1:0] r_out_pos, n_out_pos;
    logic [REF_W-1:0]          r_out_ref, n_out_ref;
    logic                      r_out_last, n_out_last;

    logic [KLEN_W-1:0]   w_k;
    logic [KEY_W-1:0]    w_mask;
    logic [CNT_W-1:0]    w_cap;
    logic [KEY_W-1:0]    w_qkey_f;
    logic [REF_W-1:0]    w_qoff_f;
    logic                w_qstop_f;
    logic [KEY_W-1:0]    w_t_roll;
    logic [KEY_W-1:0]    w_q_roll;
    logic [KEY_W-1:0]    w_key;
    logic [IDX_W-1:0]    w_slot_idx;
    logic [CNT_W-1:0]    w_cnt_q;
    logic [CNT_W-1:0]    w_n_q;
    logic [POS_BITS-1:0] w_slot_q;
    logic                w_store_busy;
    logic                w_over_budget;
    logic                w_out_load;
    logic                w_last_hit;
    kpi_pkg::t_kpi_store_cmd s_cmd;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len   <= kpi_pkg::KMER_LEN_RST;
            r_bucket_cap <= kpi_pkg::BUCKET_CAP_RST;
            r_hit_limit  <= kpi_pkg::HIT_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                kpi_pkg::CFG_KMER_LEN:   r_kmer_len   <= i_cfg_data[KLEN_W-1:0];
                kpi_pkg::CFG_BUCKET_CAP: r_bucket_cap <= i_cfg_data[kpi_pkg::CAP_W-1:0];
                kpi_pkg::CFG_HIT_LIMIT:  r_hit_limit  <= i_cfg_data[HL_W-1:0];
                default: ;
            endcase
        end
    end

    // effective k and capacity
    always_comb begin
        if (r_kmer_len == '0) begin
            w_k = KLEN_W'(1);
        end else if (r_kmer_len > MAX_K_L) begin
            w_k = MAX_K_L;
        end else begin
            w_k = r_kmer_len;
        end
        w_cap = (r_bucket_cap > SLOTS_C) ? CNT_W'(SLOTS) : CNT_W'(r_bucket_cap);
    end

    // key keeps 2k bits
    always_comb begin
        for (int i = 0; i < KEY_W; i++) begin
            w_mask[i] = (5'(i) < {w_k, 1'b0});
        end
    end

    // query state as seen after an optional restart
    assign w_qkey_f  = i_first_of_query ? '0 : r_qkey;
    assign w_qoff_f  = i_first_of_query ? '0 : r_qoffset;
    assign w_qstop_f = i_first_of_query ? 1'b0 : r_qstopped;
    assign w_t_roll  = KEY_W'({r_tkey, i_base}) & w_mask;
    assign w_q_roll  = KEY_W'({w_qkey_f, i_base}) & w_mask;

    assign w_key      = r_is_query ? r_qkey : r_tkey;
    assign w_slot_idx = r_is_query ? IDX_W'(r_idx) : IDX_W'(w_cnt_q);
    assign w_n_q      = (w_cnt_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : w_cnt_q;
    assign w_over_budget = ({1'b0, r_hits} + (HL_W + 1)'(w_n_q)) > {1'b0, r_hit_limit};
    assign w_out_load = !r_out_valid || i_out_ready;
    assign w_last_hit = (r_idx == r_n - CNT_W'(1));

    kpi_store #(
        .MAX_K    (MAX_K),
        .SLOTS    (SLOTS),
        .POS_BITS (POS_BITS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .i_key        (w_key),
        .i_slot_idx   (w_slot_idx),
        .i_cnt_wdata  (w_cnt_q + CNT_W'(1)),
        .i_slot_wdata (r_tcount - POS_BITS'(w_k)),
        .o_cnt_q      (w_cnt_q),
        .o_slot_q     (w_slot_q),
        .o_busy       (w_store_busy)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kpi_pkg::ST_CLEAR;
            r_tkey      <= '0;
            r_tcount    <= '0;
            r_qkey      <= '0;
            r_qoffset   <= '0;
            r_qorigin   <= '0;
            r_hits      <= '0;
            r_qstopped  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tkey      <= n_tkey;
            r_tcount    <= n_tcount;
            r_qkey      <= n_qkey;
            r_qoffset   <= n_qoffset;
            r_qorigin   <= n_qorigin;
            r_hits      <= n_hits;
            r_qstopped  <= n_qstopped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_query  <= n_is_query;
        r_ref_start <= n_ref_start;
        r_n         <= n_n;
        r_idx       <= n_idx;
        r_out_pos   <= n_out_pos;
        r_out_ref   <= n_out_ref;
        r_out_last  <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_tkey      = r_tkey;
        n_tcount    = r_tcount;
        n_qkey      = r_qkey;
        n_qoffset   = r_qoffset;
        n_qorigin   = r_qorigin;
        n_hits      = r_hits;
        n_qstopped  = r_qstopped;
        n_is_query  = r_is_query;
        n_ref_start = r_ref_start;
        n_n         = r_n;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_pos   = r_out_pos;
        n_out_ref   = r_out_ref;
        n_out_last  = r_out_last;
        s_cmd       = '0;
        o_in_ready  = 1'b0;

        case (r_state)
            kpi_pkg::ST_CLEAR: begin
                if (!w_store_busy) begin
                    n_state = kpi_pkg::ST_IDLE;
                end
            end

            kpi_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_operation)
                        kpi_pkg::OP_CLEAR: begin
                            n_tkey            = '0;
                            n_tcount          = '0;
                            s_cmd.clear_start = 1'b1;
                            n_state           = kpi_pkg::ST_CLEAR;
                        end
                        kpi_pkg::OP_TARGET: begin
                            // target saturates at the last position
                            if (r_tcount != '1) begin
                                n_tkey     = w_t_roll;
                                n_tcount   = r_tcount + POS_BITS'(1);
                                n_is_query = 1'b0;
                                if (n_tcount >= POS_BITS'(w_k)) begin
                                    n_state = kpi_pkg::ST_LOOKUP;
                                end
                            end
                        end
                        kpi_pkg::OP_QUERY: begin
                            n_qkey     = w_qkey_f;
                            n_qoffset  = w_qoff_f;
                            n_qstopped = w_qstop_f;
                            if (i_first_of_query) begin
                                n_qorigin = i_query_start;
                                n_hits    = '0;
                            end
                            if (w_qoff_f != '1) begin
                                n_qkey     = w_q_roll;
                                n_qoffset  = w_qoff_f + REF_W'(1);
                                n_is_query = 1'b1;
                                if (n_qoffset >= REF_W'(w_k) && !w_qstop_f) begin
                                    n_state = kpi_pkg::ST_LOOKUP;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            kpi_pkg::ST_LOOKUP: begin
                s_cmd.cnt_rd = 1'b1;
                n_ref_start  = r_qorigin + r_qoffset - REF_W'(w_k);
                n_state      = kpi_pkg::ST_COUNT;
            end

            kpi_pkg::ST_COUNT: begin
                n_state = kpi_pkg::ST_IDLE;
                if (!r_is_query) begin
                    if (w_cnt_q < w_cap) begin
                        s_cmd.cnt_wr  = 1'b1;
                        s_cmd.slot_wr = 1'b1;
                    end
                end else if (w_n_q != '0) begin
                    if (w_over_budget) begin
                        n_qstopped = 1'b1;
                    end else begin
                        n_hits  = r_hits + HL_W'(w_n_q);
                        n_n     = w_n_q;
                        n_idx   = '0;
                        n_state = kpi_pkg::ST_SLOT_RD;
                    end
                end
            end

            kpi_pkg::ST_SLOT_RD: begin
                s_cmd.slot_rd = 1'b1;
                n_state       = kpi_pkg::ST_SLOT_OUT;
            end

            kpi_pkg::ST_SLOT_OUT: begin
                // slot data holds until the result register frees up
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = kpi_pkg::TPOS_W'(w_slot_q);
                    n_out_ref   = r_ref_start;
                    n_out_last  = w_last_hit;
                    if (w_last_hit) begin
                        n_state = kpi_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = kpi_pkg::ST_SLOT_RD;
                    end
                end
            end

            default: begin
                n_state = kpi_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_target_pos = r_out_pos;
    assign o_ref_start  = r_out_ref;
    assign o_last       = r_out_last;

`ifndef SYNTH
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == kpi_pkg::ST_SLOT_OUT)
        else $error("result word appeared outside the emit state");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kpi_pkg::ST_SLOT_RD || r_state == kpi_pkg::ST_SLOT_OUT) |-> r_idx < r_n)
        else $error("slot index ran past the bucket count");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_store_busy |-> !o_in_ready)
        else $error("input taken during count sweep");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == kpi_pkg::ST_COUNT |-> w_cnt_q <= CNT_W'(SLOTS))
        else $error("bucket count above slot depth");

    a_slot_wr_with_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.slot_wr |-> s_cmd.cnt_wr && !w_store_busy)
        else $error("slot write without count update");
`endif

endmodule

// ----- sim/kmer_position_index_core_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the k-mer position index core: directed and random base streams.
module kmer_position_index_core_test;

    localparam logic [kpi_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 16;
    localparam int CLEAR_CYCLES   = (1 << (2 * kpi_pkg::MAX_K_DEF)) + 64;
    localparam int WATCHDOG_LIMIT = 300000;

    typedef struct {
        bit [kpi_pkg::TPOS_W-1:0] tpos;
        bit [kpi_pkg::REF_W-1:0]  refb;
        bit                       last;
    } t_hit_word;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [kpi_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [kpi_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic [kpi_pkg::OP_W-1:0]       i_operation;
    logic [kpi_pkg::BASE_W-1:0]     i_base;
    logic                           i_first_of_query;
    logic [kpi_pkg::REF_W-1:0]      i_query_start;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [kpi_pkg::TPOS_W-1:0]     o_target_pos;
    logic [kpi_pkg::REF_W-1:0]      o_ref_start;
    logic                           o_last;

    kmer_position_index_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_base           (i_base),
        .i_first_of_query (i_first_of_query),
        .i_query_start    (i_query_start),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_target_pos     (o_target_pos),
        .o_ref_start      (o_ref_start),
        .o_last           (o_last)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Index model state
    bit [kpi_pkg::KLEN_W-1:0] kmer_len_reg;
    bit [kpi_pkg::CAP_W-1:0]  bucket_cap_reg;
    bit [kpi_pkg::HL_W-1:0]   hit_limit_reg;
    bit [6:0]                 bucket_fill [0:(1 << (2 * kpi_pkg::MAX_K_DEF)) - 1];
    bit [kpi_pkg::TPOS_W-1:0] slot_pos [int];
    bit [15:0]                tgt_key;
    bit [kpi_pkg::TPOS_W-1:0] tgt_count;
    bit [15:0]                qry_key;
    bit [kpi_pkg::REF_W-1:0]  qry_offset;
    bit [kpi_pkg::REF_W-1:0]  qry_origin;
    bit [kpi_pkg::HL_W-1:0]   hits_used;
    bit                       qry_muted;

    t_hit_word   pending_hits[$];
    t_hit_word   want_hit;
    int unsigned in_gap_max;
    int unsigned out_stall_max;
    bit          clear_busy;
    int unsigned errors;
    int unsigned words_sent;
    int unsigned hits_checked;
    int unsigned reg_writes;
    int unsigned idle_cycles;

    function automatic int unsigned eff_kmer_len();
        if (kmer_len_reg == 0) return 1;
        if (kmer_len_reg > kpi_pkg::MAX_K_DEF) return kpi_pkg::MAX_K_DEF;
        return kmer_len_reg;
    endfunction

    function automatic bit [15:0] roll_key(input bit [15:0] key, input bit [1:0] b,
                                           input int unsigned k);
        bit [31:0] mask;
        mask = (32'd1 << (2 * k)) - 32'd1;
        return 16'((({16'd0, key} << 2) | 32'(b)) & mask);
    endfunction

    // Works out the hit words that one accepted input word produces.
    function automatic void predict_hits(input bit [kpi_pkg::OP_W-1:0] op, input bit [1:0] b,
                                         input bit first, input bit [kpi_pkg::REF_W-1:0] qs);
        int unsigned k;
        int unsigned n;
        int unsigned cap;
        bit [kpi_pkg::REF_W-1:0] refb;
        t_hit_word h;
        k = eff_kmer_len();
        case (op)
            kpi_pkg::OP_CLEAR: begin
                foreach (bucket_fill[i]) bucket_fill[i] = '0;
                tgt_count = '0;
                tgt_key = '0;
            end
            kpi_pkg::OP_TARGET: begin
                // target stream saturates at the last position code
                if (tgt_count != {kpi_pkg::TPOS_W{1'b1}}) begin
                    tgt_key = roll_key(tgt_key, b, k);
                    tgt_count++;
                    if (tgt_count >= k) begin
                        n = bucket_fill[tgt_key];
                        cap = (bucket_cap_reg > kpi_pkg::SLOTS_DEF) ?
                              kpi_pkg::SLOTS_DEF : bucket_cap_reg;
                        if (n < cap) begin
                            slot_pos[int'(tgt_key) * kpi_pkg::SLOTS_DEF + n] =
                                kpi_pkg::TPOS_W'(tgt_count - k);
                            bucket_fill[tgt_key] = 7'(n + 1);
                        end
                    end
                end
            end
            kpi_pkg::OP_QUERY: begin
                if (first) begin
                    qry_key = '0;
                    qry_offset = '0;
                    qry_origin = qs;
                    hits_used = '0;
                    qry_muted = 1'b0;
                end
                if (qry_offset != {kpi_pkg::REF_W{1'b1}}) begin
                    qry_key = roll_key(qry_key, b, k);
                    qry_offset++;
                    if (qry_offset >= k && !qry_muted) begin
                        n = bucket_fill[qry_key];
                        if (n > kpi_pkg::SLOTS_DEF) n = kpi_pkg::SLOTS_DEF;
                        if (n != 0) begin
                            if (int'(hits_used) + n > int'(hit_limit_reg)) begin
                                qry_muted = 1'b1;
                            end else begin
                                refb = qry_origin + qry_offset - 32'(k);
                                for (int i = 0; i < n; i++) begin
                                    h.tpos = slot_pos[int'(qry_key) * kpi_pkg::SLOTS_DEF + i];
                                    h.refb = refb;
                                    h.last = (i + 1 == n);
                                    pending_hits.push_back(h);
                                end
                                hits_used = kpi_pkg::HL_W'(int'(hits_used) + n);
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(input bit [kpi_pkg::OP_W-1:0] op, input bit [1:0] b,
                             input bit first, input bit [kpi_pkg::REF_W-1:0] qs);
        int unsigned gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_base           <= b;
        i_first_of_query <= first;
        i_query_start    <= qs;
        do @(posedge i_clk); while (!o_in_ready);
        predict_hits(op, b, first, qs);
        clear_busy = (op == kpi_pkg::OP_CLEAR);
        words_sent++;
    endtask

    // Waits until every predicted hit word has come back and the core has gone idle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (clear_busy ? CLEAR_CYCLES : SETTLE_CYCLES) @(posedge i_clk);
        clear_busy = 1'b0;
    endtask

    task automatic write_reg(input bit [kpi_pkg::CFG_IDX_W-1:0] idx,
                             input bit [kpi_pkg::HL_W-1:0] value);
        bit [kpi_pkg::CFG_DATA_W-1:0] data;
        // bits above the register width are don't-care
        data = kpi_pkg::CFG_DATA_W'($urandom);
        case (idx)
            kpi_pkg::CFG_KMER_LEN: begin
                data[kpi_pkg::KLEN_W-1:0] = value[kpi_pkg::KLEN_W-1:0];
                kmer_len_reg = value[kpi_pkg::KLEN_W-1:0];
            end
            kpi_pkg::CFG_BUCKET_CAP: begin
                data[kpi_pkg::CAP_W-1:0] = value[kpi_pkg::CAP_W-1:0];
                bucket_cap_reg = value[kpi_pkg::CAP_W-1:0];
            end
            default: begin
                data = value;
                hit_limit_reg = value;
            end
        endcase
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
    endtask

    function automatic bit [1:0] draw_base(input int unsigned zero_pct);
        if ($urandom_range(0, 99) < zero_pct) return 2'd0;
        return 2'($urandom_range(0, 3));
    endfunction

    function automatic bit [kpi_pkg::REF_W-1:0] draw_origin();
        // bias some origins toward the top so the reference start wraps
        if ($urandom_range(0, 3) == 0) return 32'hFFFF_FFF0 | $urandom_range(0, 15);
        return $urandom;
    endfunction

    // One random phase: set registers, clear, load a target, then run queries that
    // mostly copy target windows with a few mutations, mixed with noise words.
    task automatic run_index_phase(input int unsigned n_words, input bit [3:0] k,
                                   input bit [6:0] cap, input bit [13:0] lim,
                                   input int unsigned zero_pct,
                                   input int unsigned in_gap, input int unsigned out_stall);
        bit [1:0] tgt_bases[$];
        bit [1:0] b;
        int unsigned sent;
        int unsigned kk;
        int unsigned q_len;
        int unsigned start;
        int unsigned r;
        drain_results();
        write_reg(kpi_pkg::CFG_KMER_LEN, 14'(k));
        write_reg(kpi_pkg::CFG_BUCKET_CAP, 14'(cap));
        write_reg(kpi_pkg::CFG_HIT_LIMIT, lim);
        in_gap_max = in_gap;
        out_stall_max = out_stall;
        kk = eff_kmer_len();
        send_word(kpi_pkg::OP_CLEAR, 2'($urandom), 1'($urandom), $urandom);
        sent = 1;
        repeat (n_words * 2 / 5) begin
            if ($urandom_range(0, 19) == 0) begin
                send_word(OP_UNUSED, 2'($urandom), 1'($urandom), $urandom);
            end else begin
                b = draw_base(zero_pct);
                send_word(kpi_pkg::OP_TARGET, b, 1'($urandom), $urandom);
                tgt_bases.push_back(b);
                sent++;
            end
        end
        while (sent < n_words) begin
            q_len = $urandom_range(1, kk + 6);
            start = $urandom_range(0, tgt_bases.size() - 1);
            for (int i = 0; i < q_len; i++) begin
                if (start + i < tgt_bases.size() && $urandom_range(0, 9) != 0)
                    b = tgt_bases[start + i];
                else
                    b = draw_base(zero_pct);
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    send_word(OP_UNUSED, b, 1'($urandom), $urandom);
                end else if (r < 8) begin
                    send_word(kpi_pkg::OP_TARGET, b, 1'($urandom), $urandom);
                    tgt_bases.push_back(b);
                    sent++;
                end else begin
                    // a stray first flag restarts the query mid-window
                    send_word(kpi_pkg::OP_QUERY, b, (i == 0) || (r < 11), draw_origin());
                    sent++;
                end
            end
        end
    endtask

    task automatic test_unused_and_clear();
        write_reg(kpi_pkg::CFG_KMER_LEN, 14'd0);
        write_reg(kpi_pkg::CFG_BUCKET_CAP, 14'd64);
        write_reg(kpi_pkg::CFG_HIT_LIMIT, 14'd16383);
        send_word(OP_UNUSED, 2'd3, 1'b1, 32'hFFFF_FFFF);
        send_word(kpi_pkg::OP_CLEAR, 2'd0, 1'b1, 32'h0);
    endtask

    task automatic test_single_base_hits();
        // first flag on target words is ignored
        send_word(kpi_pkg::OP_TARGET, 2'd3, 1'b1, 32'hFFFF_FFFF);
        send_word(kpi_pkg::OP_TARGET, 2'd3, 1'b0, 32'h0);
        send_word(kpi_pkg::OP_TARGET, 2'd0, 1'b0, 32'h0);
        send_word(kpi_pkg::OP_QUERY, 2'd3, 1'b1, 32'hFFFF_FFFF);
        send_word(kpi_pkg::OP_QUERY, 2'd1, 1'b0, 32'h0);
        send_word(kpi_pkg::OP_QUERY, 2'd0, 1'b0, 32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic test_full_bucket();
        write_reg(kpi_pkg::CFG_KMER_LEN, 14'd1);
        write_reg(kpi_pkg::CFG_BUCKET_CAP, 14'd1);
        send_word(kpi_pkg::OP_TARGET, 2'd3, 1'b0, 32'h0);
        send_word(kpi_pkg::OP_TARGET, 2'd1, 1'b0, 32'h0);
        drain_results();
        write_reg(kpi_pkg::CFG_BUCKET_CAP, 14'd0);
        send_word(kpi_pkg::OP_TARGET, 2'd2, 1'b0, 32'h0);
        send_word(kpi_pkg::OP_QUERY, 2'd2, 1'b1, 32'h0);
        send_word(kpi_pkg::OP_QUERY, 2'd1, 1'b0, 32'h0);
        drain_results();
    endtask

    task automatic test_hit_budget();
        write_reg(kpi_pkg::CFG_HIT_LIMIT, 14'd2);
        send_word(kpi_pkg::OP_QUERY, 2'd3, 1'b1, 32'h8000_0000);
        send_word(kpi_pkg::OP_QUERY, 2'd1, 1'b0, 32'h0);
        send_word(kpi_pkg::OP_QUERY, 2'd3, 1'b0, 32'h0);
        send_word(kpi_pkg::OP_QUERY, 2'd1, 1'b1, 32'h1234_5678);
        drain_results();
        // budget applies to the very first k-mer too
        write_reg(kpi_pkg::CFG_HIT_LIMIT, 14'd0);
        send_word(kpi_pkg::OP_QUERY, 2'd3, 1'b1, 32'h0);
        send_word(kpi_pkg::OP_QUERY, 2'd2, 1'b1, 32'h0);
        drain_results();
    endtask

    task automatic test_random_streams();
        run_index_phase(130, 4'd0, 7'd127, 14'd16383, 70, 0, 0);
        run_index_phase(130, 4'd3, 7'd8, 14'd40, 20, 12, 12);
        run_index_phase(130, 4'd15, 7'd50, 14'd10000, 0, 12, 0);
        run_index_phase(130, 4'd8, 7'd1, 14'd1, 30, 0, 12);
        drain_results();
    endtask

    // Result side: random stalls drawn per word
    initial begin
        int unsigned stall;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = $urandom_range(0, out_stall_max);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            hits_checked++;
            if (pending_hits.size() == 0) begin
                errors++;
                $display("%0t: unexpected hit word: expected none, got pos %h ref %h last %b",
                         $time, o_target_pos, o_ref_start, o_last);
            end else begin
                want_hit = pending_hits.pop_front();
                if (want_hit.tpos !== o_target_pos) begin
                    errors++;
                    $display("%0t: target_pos expected %h got %h",
                             $time, want_hit.tpos, o_target_pos);
                end
                if (want_hit.refb !== o_ref_start) begin
                    errors++;
                    $display("%0t: ref_start expected %h got %h",
                             $time, want_hit.refb, o_ref_start);
                end
                if (want_hit.last !== o_last) begin
                    errors++;
                    $display("%0t: last expected %b got %b", $time, want_hit.last, o_last);
                end
            end
        end
    end

    // Ends the run when no word moves on any channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_operation      <= kpi_pkg::OP_CLEAR;
        i_base           <= '0;
        i_first_of_query <= 1'b0;
        i_query_start    <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= kpi_pkg::CFG_KMER_LEN;
        i_cfg_data       <= '0;
        idle_cycles      = 0;
        kmer_len_reg     = kpi_pkg::KMER_LEN_RST;
        bucket_cap_reg   = kpi_pkg::BUCKET_CAP_RST;
        hit_limit_reg    = kpi_pkg::HIT_LIMIT_RST;
        foreach (bucket_fill[i]) bucket_fill[i] = '0;
        tgt_key = '0;
        tgt_count = '0;
        qry_key = '0;
        qry_offset = '0;
        qry_origin = '0;
        hits_used = '0;
        qry_muted = 1'b0;
        in_gap_max = 12;
        out_stall_max = 12;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unused_and_clear();
        test_single_base_hits();
        test_full_bucket();
        test_hit_budget();
        test_random_streams();

        $display("Covered %0d input words, %0d hit words and %0d register writes,",
                 words_sent, hits_checked, reg_writes);
        $display("k-mer lengths 1 to 8, capacities 0 to 127, hit limits 0 to 16383.");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/kpi_pkg.sv
rtl/kpi_store.sv
rtl/kmer_position_index_core.sv
sim/kmer_position_index_core_test.sv
